>>> rtl/hvc_pkg.sv
package hvc_pkg;

    localparam int ANGLE_ITERATIONS_DEF = 16;
    localparam int ATAN_ENTRIES         = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINEAR_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_STEP_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_STEP_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT_ON      = 3'd4;

    localparam int DXY_W = 33;
    localparam int XY_W  = 36;
    localparam int Z_W   = 29;
    localparam int ERR_W = 20;
    localparam int W_W   = 24;
    localparam int V_W   = 20;

    localparam logic signed [Z_W-1:0]   PI24      = 29'sd52707179;
    localparam logic signed [ERR_W-1:0] PI13      = 20'sd25736;
    localparam logic signed [ERR_W-1:0] TWO_PI13  = 20'sd51472;
    localparam logic signed [ERR_W-1:0] HALF_PI13 = 20'sd12868;

    typedef struct packed {
        logic [14:0] max_linear_speed;
        logic [14:0] turn_gain;
        logic [14:0] linear_step_limit;
        logic [14:0] angular_step_limit;
        logic        rate_limit_on;
    } hvc_cfg_t;

    typedef struct packed {
        logic signed [DXY_W-1:0] dx;
        logic signed [DXY_W-1:0] dy;
        logic signed [15:0]      heading;
        logic [16:0]             scale;
        logic                    stop;
    } hvc_item_t;

    typedef struct packed {
        logic               out_load;
        logic signed [15:0] prev_angular;
    } hvc_status_t;

    // Arctangent of 2^-i in radians scaled by 2^24, rounded.
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [Z_W-1:0] val;
        unique case (idx)
            5'd0:    val = 29'sd13176795;
            5'd1:    val = 29'sd7778716;
            5'd2:    val = 29'sd4110060;
            5'd3:    val = 29'sd2086331;
            5'd4:    val = 29'sd1047214;
            5'd5:    val = 29'sd524117;
            5'd6:    val = 29'sd262123;
            5'd7:    val = 29'sd131069;
            5'd8:    val = 29'sd65536;
            5'd9:    val = 29'sd32768;
            5'd10:   val = 29'sd16384;
            5'd11:   val = 29'sd8192;
            5'd12:   val = 29'sd4096;
            5'd13:   val = 29'sd2048;
            5'd14:   val = 29'sd1024;
            5'd15:   val = 29'sd512;
            5'd16:   val = 29'sd256;
            5'd17:   val = 29'sd128;
            5'd18:   val = 29'sd64;
            5'd19:   val = 29'sd32;
            5'd20:   val = 29'sd16;
            5'd21:   val = 29'sd8;
            5'd22:   val = 29'sd4;
            5'd23:   val = 29'sd2;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/hvc_if.sv
interface hvc_req_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] robot_x;
    logic signed [31:0] robot_y;
    logic signed [15:0] robot_heading;
    logic [16:0]        speed_scale;
    logic               stop;

    modport source (output valid, goal_x, goal_y, robot_x, robot_y, robot_heading,
                    speed_scale, stop, input ready);
    modport sink (input valid, goal_x, goal_y, robot_x, robot_y, robot_heading,
                  speed_scale, stop, output ready);
endinterface

interface hvc_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] linear_vel;
    logic signed [15:0] angular_vel;

    modport source (output valid, linear_vel, angular_vel, input ready);
    modport sink (input valid, linear_vel, angular_vel, output ready);
endinterface

>>> rtl/hvc_front.sv
module hvc_front (
    input  logic              clk,
    input  logic              rst_n,
    hvc_req_if.sink           req,
    output hvc_pkg::hvc_item_t q_item,
    output logic              q_valid,
    input  logic              q_ready
);
    import hvc_pkg::*;

    hvc_item_t  fifo_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    hvc_item_t  new_item;

    // Offsets to the goal are formed on entry so the back end starts on the angle at once.
    always_comb
    begin
        new_item.dx      = {req.goal_x[31], req.goal_x} - {req.robot_x[31], req.robot_x};
        new_item.dy      = {req.goal_y[31], req.goal_y} - {req.robot_y[31], req.robot_y};
        new_item.heading = req.robot_heading;
        new_item.scale   = req.speed_scale;
        new_item.stop    = req.stop;
    end

    assign req.ready = (count_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != 2'd0);
    assign pop       = q_valid && q_ready;
    assign q_item    = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/hvc_back.sv
module hvc_back #(
    parameter int ANGLE_ITERATIONS = hvc_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hvc_pkg::hvc_cfg_t   cfg,
    input  hvc_pkg::hvc_item_t  q_item,
    input  logic                q_valid,
    output logic                q_ready,
    hvc_rsp_if.source           rsp,
    output hvc_pkg::hvc_status_t status
);
    import hvc_pkg::*;

    localparam int ITER_W = (ANGLE_ITERATIONS > 1) ? $clog2(ANGLE_ITERATIONS) : 1;
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(ANGLE_ITERATIONS - 1);
    localparam logic [4:0] DIV_LAST = 5'd16;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CORD = 4'd1;
    localparam logic [3:0] S_ERR  = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_LIM  = 4'd4;
    localparam logic [3:0] S_NUM  = 4'd5;
    localparam logic [3:0] S_PREP = 4'd6;
    localparam logic [3:0] S_DCHK = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;

    logic [3:0]              state_reg;
    logic [3:0]              state_next;
    logic [ITER_W-1:0]       iter_reg;
    logic [4:0]              div_cnt_reg;

    logic signed [XY_W-1:0]  x_reg;
    logic signed [XY_W-1:0]  y_reg;
    logic signed [Z_W-1:0]   z_reg;
    logic                    zero_reg;
    logic                    stop_reg;
    logic signed [15:0]      heading_reg;
    logic [16:0]             scale_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [35:0]      wprod_reg;
    logic [31:0]             p1_reg;
    logic signed [W_W-1:0]   w_reg;
    logic signed [57:0]      num_reg;
    logic                    neg_reg;
    logic [41:0]             n2_reg;
    logic [16:0]             nbits_reg;
    logic [14:0]             rem_reg;
    logic [17:0]             quo_reg;
    logic signed [15:0]      prev_lin_reg;
    logic signed [15:0]      prev_ang_reg;
    logic                    out_valid_reg;
    logic signed [15:0]      out_lin_reg;
    logic signed [15:0]      out_ang_reg;

    logic                    pop;
    logic                    out_free;
    logic                    out_load;
    logic signed [XY_W-1:0]  dx_ext;
    logic signed [XY_W-1:0]  dy_ext;
    logic signed [XY_W-1:0]  sx;
    logic signed [XY_W-1:0]  sy;
    logic signed [Z_W-1:0]   atan_val;
    logic signed [Z_W-1:0]   z_round;
    logic signed [ERR_W-1:0] err_raw;
    logic signed [ERR_W-1:0] err_wrap;
    logic signed [35:0]      w_round;
    logic signed [W_W-1:0]   w_raw;
    logic signed [W_W-1:0]   w_lo;
    logic signed [W_W-1:0]   w_hi;
    logic signed [W_W-1:0]   w_lim;
    logic [W_W-1:0]          w_mag;
    logic signed [W_W:0]     d_term;
    logic [57:0]             num_mag;
    logic [57:0]             n2_sum;
    logic [15:0]             div_trial;
    logic                    div_take;
    logic signed [V_W-1:0]   v_pre;
    logic signed [V_W-1:0]   v_hi;
    logic signed [V_W-1:0]   v_lim;
    logic signed [15:0]      v_sat;
    logic signed [15:0]      w_sat;
    logic                    err_small;

    assign q_ready  = (state_reg == S_IDLE);
    assign pop      = q_valid && q_ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign out_load = (state_reg == S_FIN) && out_free;

    assign rsp.valid       = out_valid_reg;
    assign rsp.linear_vel  = out_lin_reg;
    assign rsp.angular_vel = out_ang_reg;

    assign status.out_load     = out_load;
    assign status.prev_angular = prev_ang_reg;

    always_comb
    begin
        dx_ext   = XY_W'(q_item.dx);
        dy_ext   = XY_W'(q_item.dy);
        sx       = x_reg >>> iter_reg;
        sy       = y_reg >>> iter_reg;
        atan_val = atan_entry(5'(iter_reg));

        z_round  = (z_reg + 29'sd1024) >>> 11;
        err_raw  = (zero_reg ? 20'sd0 : ERR_W'(z_round)) - ERR_W'(heading_reg);
        if (err_raw > PI13)
        begin
            err_wrap = err_raw - TWO_PI13;
        end
        else if (err_raw < -PI13)
        begin
            err_wrap = err_raw + TWO_PI13;
        end
        else
        begin
            err_wrap = err_raw;
        end

        // The angular bound acts only on the side the new command points to.
        w_round = (wprod_reg + 36'sd4096) >>> 13;
        w_raw   = W_W'(w_round);
        w_lo    = W_W'(prev_ang_reg) - W_W'({1'b0, cfg.angular_step_limit});
        w_hi    = W_W'(prev_ang_reg) + W_W'({1'b0, cfg.angular_step_limit});
        w_lim   = w_raw;
        if (cfg.rate_limit_on)
        begin
            if (w_raw < 0)
            begin
                if (w_raw < w_lo)
                begin
                    w_lim = w_lo;
                end
            end
            else if (w_raw > w_hi)
            begin
                w_lim = w_hi;
            end
        end

        w_mag   = w_reg[W_W-1] ? W_W'(-w_reg) : W_W'(w_reg);
        d_term  = $signed({10'b0, cfg.turn_gain}) - $signed({1'b0, w_mag});
        num_mag = num_reg[57] ? 58'(-num_reg) : 58'(num_reg);
        n2_sum  = num_mag + {28'b0, cfg.turn_gain, 15'b0};

        div_trial = {rem_reg, nbits_reg[16]};
        div_take  = (div_trial >= {1'b0, cfg.turn_gain});

        err_small = (err_reg < HALF_PI13) && (err_reg > -HALF_PI13);
        if (stop_reg)
        begin
            v_pre = '0;
        end
        else if (err_reg == 0)
        begin
            v_pre = V_W'({1'b0, cfg.max_linear_speed});
        end
        else if (err_small)
        begin
            if (cfg.turn_gain == 15'd0)
            begin
                v_pre = V_W'({1'b0, 17'((33'(p1_reg) + 33'd32768) >> 16)});
            end
            else
            begin
                v_pre = neg_reg ? -V_W'({1'b0, quo_reg}) : V_W'({1'b0, quo_reg});
            end
        end
        else
        begin
            v_pre = '0;
        end
        v_hi  = V_W'(prev_lin_reg) + V_W'({1'b0, cfg.linear_step_limit});
        v_lim = (cfg.rate_limit_on && !stop_reg && (v_pre > v_hi)) ? v_hi : v_pre;

        if (v_lim > 20'sd32767)
        begin
            v_sat = 16'sh7fff;
        end
        else if (v_lim < -20'sd32768)
        begin
            v_sat = -16'sh8000;
        end
        else
        begin
            v_sat = 16'(v_lim);
        end

        if (stop_reg)
        begin
            w_sat = '0;
        end
        else if (w_reg > 24'sd32767)
        begin
            w_sat = 16'sh7fff;
        end
        else if (w_reg < -24'sd32768)
        begin
            w_sat = -16'sh8000;
        end
        else
        begin
            w_sat = 16'(w_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    state_next = q_item.stop ? S_FIN : S_CORD;
                end
            end
            S_CORD:
            begin
                if (iter_reg == ITER_LAST)
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:  state_next = S_MUL;
            S_MUL:  state_next = S_LIM;
            S_LIM:  state_next = S_NUM;
            S_NUM:  state_next = S_PREP;
            S_PREP: state_next = S_DCHK;
            S_DCHK:
            begin
                state_next = (n2_reg >= {10'b0, cfg.turn_gain, 17'b0}) ? S_FIN : S_DIV;
            end
            S_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    stop_reg    <= q_item.stop;
                    heading_reg <= q_item.heading;
                    scale_reg   <= q_item.scale;
                    zero_reg    <= (q_item.dx == 0) && (q_item.dy == 0);
                    iter_reg    <= '0;
                    if (q_item.dx < 0)
                    begin
                        x_reg <= -dx_ext;
                        y_reg <= -dy_ext;
                        z_reg <= (q_item.dy >= 0) ? PI24 : -PI24;
                    end
                    else
                    begin
                        x_reg <= dx_ext;
                        y_reg <= dy_ext;
                        z_reg <= '0;
                    end
                end
            end
            S_CORD:
            begin
                iter_reg <= iter_reg + 1'b1;
                if (!y_reg[XY_W-1])
                begin
                    x_reg <= x_reg + sy;
                    y_reg <= y_reg - sx;
                    z_reg <= z_reg + atan_val;
                end
                else
                begin
                    x_reg <= x_reg - sy;
                    y_reg <= y_reg + sx;
                    z_reg <= z_reg - atan_val;
                end
            end
            S_ERR:  err_reg <= err_wrap;
            S_MUL:
            begin
                wprod_reg <= $signed({1'b0, cfg.turn_gain}) * err_reg;
                p1_reg    <= cfg.max_linear_speed * scale_reg;
            end
            S_LIM:  w_reg <= w_lim;
            S_NUM:  num_reg <= $signed({1'b0, p1_reg}) * d_term;
            S_PREP:
            begin
                n2_reg  <= n2_sum[57:16];
                neg_reg <= num_reg[57];
            end
            S_DCHK:
            begin
                div_cnt_reg <= '0;
                if (n2_reg >= {10'b0, cfg.turn_gain, 17'b0})
                begin
                    quo_reg <= 18'h20000;
                end
                else
                begin
                    quo_reg   <= '0;
                    rem_reg   <= n2_reg[31:17];
                    nbits_reg <= n2_reg[16:0];
                end
            end
            S_DIV:
            begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
                nbits_reg   <= {nbits_reg[15:0], 1'b0};
                quo_reg     <= {quo_reg[16:0], div_take};
                rem_reg     <= div_take ? 15'(div_trial - {1'b0, cfg.turn_gain})
                                        : 15'(div_trial);
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    out_lin_reg <= v_sat;
                    out_ang_reg <= w_sat;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            prev_lin_reg  <= '0;
            prev_ang_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                prev_lin_reg  <= v_sat;
                prev_ang_reg  <= w_sat;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/heading_velocity_command_core.sv
// Heading and velocity command core for a unicycle robot.
// The req channel carries one word per control tick: goal and robot position,
// robot heading, a speed scale and a stop flag. The rsp channel returns one
// word per request with the linear and angular velocity commands, in order.
// Both channels use a valid/ready handshake; a word moves when both are high.
// Gains and step limits are set through cfg_we, cfg_index and cfg_data; the
// user must write them only while the core is idle, as the core itself does
// not enforce it. Each write takes effect at the clock edge it is seen on.
// A two-word queue sits behind req, so up to two requests are taken while a
// command is still being worked out. One request at a time is processed: the
// CORDIC bearing loop takes one rotation per cycle, six further steps follow,
// then the 17-step divider that scales the forward speed and a final step
// that loads the result. When the scaled speed is already out of range the
// divider is skipped. The back end returns to idle after each response and
// takes the next request from the queue there. A stop request goes from the
// queue straight to the final step. The response sits in an output
// register; while rsp.ready is low the result is held, the back end waits in
// its last step and the queue keeps filling. Reset clears the queue, the
// stored previous commands, the state, the output valid flag and the
// configuration; the datapath registers are not reset.
module heading_velocity_command_core #(
    parameter int ANGLE_ITERATIONS = hvc_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hvc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hvc_pkg::CFG_DATA_W-1:0] cfg_data,
    hvc_req_if.sink                       req,
    hvc_rsp_if.source                     rsp
);
    import hvc_pkg::*;

    hvc_cfg_t    cfg_reg;
    hvc_item_t   q_item;
    logic        q_valid;
    logic        q_ready;
    hvc_status_t status;

    // Configuration registers, reset to the documented defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_linear_speed   <= 15'd256;
            cfg_reg.turn_gain          <= 15'd256;
            cfg_reg.linear_step_limit  <= 15'd26;
            cfg_reg.angular_step_limit <= 15'd26;
            cfg_reg.rate_limit_on      <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_LINEAR_SPEED:   cfg_reg.max_linear_speed   <= cfg_data;
                CFG_TURN_GAIN:          cfg_reg.turn_gain          <= cfg_data;
                CFG_LINEAR_STEP_LIMIT:  cfg_reg.linear_step_limit  <= cfg_data;
                CFG_ANGULAR_STEP_LIMIT: cfg_reg.angular_step_limit <= cfg_data;
                CFG_RATE_LIMIT_ON:      cfg_reg.rate_limit_on      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // The front end forms the goal offsets and queues the request.
    hvc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_ready (q_ready)
    );

    // The back end runs the bearing loop, the control law and the divider.
    hvc_back #(
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .rsp     (rsp),
        .status  (status)
    );

    // A new response never overwrites one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.out_load |-> (!rsp.valid || rsp.ready))
        else $error("response register loaded while a word was pending");

    // The stored angular command always matches the response just issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.out_load |=> (rsp.valid && (status.prev_angular == rsp.angular_vel)))
        else $error("stored angular command differs from issued response");

endmodule
